// ----- hw/rtl/bse_pkg.sv -----
// ---------------------------------------------------------------------------
// bse_pkg
// Shared constants and types for the bubble sort engine: default sizes,
// controller states and the command/status bundles between control and
// datapath.
// ---------------------------------------------------------------------------
package bse_pkg;

  // field width of the streamed values
  localparam int VALUE_BITS = 32;

  // default sizes
  localparam int MAX_ITEMS_DEF = 64;
  localparam int ELEM_BITS_DEF = 32;

  // controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_START,
    ST_PRIME,
    ST_STEP,
    ST_PASS_END,
    ST_OUT_READ,
    ST_OUT_PUSH
  } bse_state_t;

  // source of the element store write data
  typedef enum logic [1:0] {
    WR_INPUT,
    WR_MIN,
    WR_CARRY
  } bse_wr_src_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        wr_en;
    bse_wr_src_t wr_src;
    logic        carry_load;
    logic        carry_max;
    logic        push;
    logic        push_last;
    logic        push_dropped;
  } bse_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic gt;
    logic out_free;
  } bse_stat_t;

endpackage

// ----- hw/rtl/bubble_sort_engine.sv -----
// ---------------------------------------------------------------------------
// bubble_sort_engine
// Collects a set of signed integers, sorts it ascending by bubble sort
// with early exit and streams the sorted set back out.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one element per item in tdata; tlast marks the final
//   element of a set. Items are taken one per cycle while the block loads.
//   Up to MAX_ITEMS elements are kept; further items are discarded and every
//   result of that set carries the dropped flag in m_axis_tuser.
//   After the last item s_axis_tready stays low while the set is sorted.
//   A pass over elements 0..e makes one compare per cycle on the single
//   read and write port of the element RAM; at most n-1 passes run, and
//   sorting stops after the first pass without a swap, so an already
//   sorted set takes a single pass.
//   Results then leave one per cycle through a registered output, the last
//   marked with m_axis_tlast. A stalled receiver holds the current result
//   and pauses read-out. Once the final result is in the output register
//   the block loads the next set while that result waits to be taken.
//   Reset empties the set and drops any pending result.
// ---------------------------------------------------------------------------
module bubble_sort_engine #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF,
  parameter int ELEM_BITS = bse_pkg::ELEM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bse_pkg::VALUE_BITS-1:0] s_axis_tdata,  // [31:0] value
  input  logic                           s_axis_tlast,  // last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bse_pkg::VALUE_BITS-1:0] m_axis_tdata,  // [31:0] sorted_value
  output logic                           m_axis_tlast,  // last_out
  output logic [0:0]                     m_axis_tuser   // [0] dropped
);

  import bse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  bse_cmd_t      cmd;
  bse_stat_t     stat;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  bse_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_last (s_axis_tlast),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .stat    (stat),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  bse_datapath #(
    .MAX_ITEMS(MAX_ITEMS),
    .ELEM_BITS(ELEM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .waddr      (waddr),
    .raddr      (raddr),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_dropped(m_axis_tuser[0])
  );

endmodule

// ----- hw/rtl/bse_ram.sv -----
// ---------------------------------------------------------------------------
// bse_ram
// Simple dual-port RAM: one write port, one read port with registered
// read data.
// ---------------------------------------------------------------------------
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bse_datapath.sv -----
// ---------------------------------------------------------------------------
// bse_datapath
// Element store, bubbling carry register with signed compare, and the
// output register of the result stream.
// ---------------------------------------------------------------------------
module bse_datapath #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF,
  parameter int ELEM_BITS = bse_pkg::ELEM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bse_pkg::VALUE_BITS-1:0] in_value,
  input  bse_pkg::bse_cmd_t              cmd,
  output bse_pkg::bse_stat_t             stat,
  input  logic [$clog2(MAX_ITEMS)-1:0]   waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]   raddr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bse_pkg::VALUE_BITS-1:0] out_value,
  output logic                           out_last,
  output logic                           out_dropped
);

  import bse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  logic signed [ELEM_BITS-1:0] in_ext;
  logic signed [ELEM_BITS-1:0] carry;
  logic signed [ELEM_BITS-1:0] rd_elem;
  logic [ELEM_BITS-1:0]        rdata;
  logic [ELEM_BITS-1:0]        wdata;
  logic                        gt;

  // low bits of the input, sign extended to the element width
  assign in_ext  = ELEM_BITS'(signed'(in_value));
  assign rd_elem = signed'(rdata);

  // earlier element strictly greater than the one read
  assign gt = carry > rd_elem;

  assign stat.gt       = gt;
  assign stat.out_free = !out_valid || out_ready;

  // write data selection
  always_comb begin
    case (cmd.wr_src)
      WR_INPUT: wdata = in_ext;
      WR_MIN:   wdata = gt ? rd_elem : carry;
      WR_CARRY: wdata = carry;
      default:  wdata = carry;
    endcase
  end

  bse_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr[AW-1:0]),
    .wdata(wdata),
    .raddr(raddr[AW-1:0]),
    .rdata(rdata)
  );

  // carry keeps the larger element moving up through the pass
  always_ff @(posedge clk) begin
    if (cmd.carry_load || (cmd.carry_max && !gt)) begin
      carry <= rd_elem;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_value   <= VALUE_BITS'(rd_elem);
      out_last    <= cmd.push_last;
      out_dropped <= cmd.push_dropped;
    end
  end

endmodule

// ----- hw/rtl/bse_ctrl.sv -----
// ---------------------------------------------------------------------------
// bse_ctrl
// Sequencer for load, bubble passes with early exit, and read-out of the
// sorted set. Holds the element count, overflow flag and pass indices.
// ---------------------------------------------------------------------------
module bse_ctrl #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_last,
  output logic                         in_ready,
  output bse_pkg::bse_cmd_t            cmd,
  input  bse_pkg::bse_stat_t           stat,
  output logic [$clog2(MAX_ITEMS)-1:0] waddr,
  output logic [$clog2(MAX_ITEMS)-1:0] raddr
);

  import bse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  bse_state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [AW-1:0] pass_end, pass_end_next;
  logic [AW-1:0] idx, idx_next;
  logic          swapped, swapped_next;
  logic          room;
  logic [CW-1:0] count_after;
  logic [AW-1:0] last_idx;

  assign room        = count < CW'(MAX_ITEMS);
  assign count_after = room ? count + CW'(1) : count;
  assign last_idx    = AW'(count - CW'(1));

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      pass_end <= '0;
      idx      <= '0;
      swapped  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf      <= ovf_next;
      pass_end <= pass_end_next;
      idx      <= idx_next;
      swapped  <= swapped_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    pass_end_next = pass_end;
    idx_next      = idx;
    swapped_next  = swapped;
    cmd           = '0;
    cmd.wr_src    = WR_INPUT;
    in_ready      = 1'b0;
    waddr         = idx;
    raddr         = idx;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        waddr    = count[AW-1:0];
        if (in_valid) begin
          if (room) begin
            cmd.wr_en  = 1'b1;
            count_next = count_after;
          end else begin
            ovf_next = 1'b1;
          end
          if (in_last) begin
            pass_end_next = AW'(count_after - CW'(1));
            idx_next      = '0;
            // a single element needs no sorting
            state_next    = (count_after == CW'(1)) ? ST_OUT_READ : ST_PASS_START;
          end
        end
      end
      ST_PASS_START: begin
        raddr      = '0;
        state_next = ST_PRIME;
      end
      ST_PRIME: begin
        cmd.carry_load = 1'b1;
        raddr          = AW'(1);
        idx_next       = '0;
        swapped_next   = 1'b0;
        state_next     = ST_STEP;
      end
      ST_STEP: begin
        // compare carry with element idx+1, write the smaller at idx
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = WR_MIN;
        cmd.carry_max = 1'b1;
        waddr         = idx;
        raddr         = idx + AW'(1) + AW'(1);
        swapped_next  = swapped || stat.gt;
        if ((idx + AW'(1)) == pass_end) begin
          state_next = ST_PASS_END;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_PASS_END: begin
        // park the largest at the top, start reading the next pass
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_CARRY;
        waddr      = pass_end;
        raddr      = '0;
        idx_next   = '0;
        if (!swapped || pass_end == AW'(1)) begin
          state_next = ST_OUT_PUSH;
        end else begin
          pass_end_next = pass_end - AW'(1);
          state_next    = ST_PRIME;
        end
      end
      ST_OUT_READ: begin
        raddr      = idx;
        state_next = ST_OUT_PUSH;
      end
      ST_OUT_PUSH: begin
        raddr = idx;
        if (stat.out_free) begin
          cmd.push         = 1'b1;
          cmd.push_last    = idx == last_idx;
          cmd.push_dropped = ovf;
          raddr            = idx + AW'(1);
          if (idx == last_idx) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = ST_LOAD;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bse_checker.sv -----
// ---------------------------------------------------------------------------
// bse_checker
// Port-level checks on the bubble sort engine, bound to the top level.
// ---------------------------------------------------------------------------
module bse_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [bse_pkg::VALUE_BITS-1:0] s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bse_pkg::VALUE_BITS-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic [0:0]                     m_axis_tuser
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // the last item of a set closes the input while sorting
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after the last item of a set");

  // a waiting result is not withdrawn
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  // a waiting result keeps its payload
  a_data_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("result payload changed while stalled");

endmodule

bind bubble_sort_engine bse_checker u_bse_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bubble sort engine. Sets of signed elements
// are streamed in, an internal sorter predicts the ordered read-out of each
// set and every result item is checked field by field as it leaves.
// Idling on both sides, a long receiver hold-off and an oversized set that
// overruns the element store are part of the run.
// ---------------------------------------------------------------------------
module tb_top;
  import bse_pkg::*;

  localparam int MAX_ITEMS      = MAX_ITEMS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int DIRECTED_LEN   = 21;

  // one element item as offered to the block
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_last;
  } elem_item_t;

  // one predicted result item
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         is_last;
    logic                         dropped;
  } sorted_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VALUE_BITS-1:0] s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [VALUE_BITS-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;

  bubble_sort_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .s_axis_tlast  (s_axis_tlast),   // last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] sorted_value
    .m_axis_tlast  (m_axis_tlast),   // last_out
    .m_axis_tuser  (m_axis_tuser)    // [0] dropped
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and prediction state
  elem_item_t                   pending_q[$];
  sorted_item_t                 sorted_q[$];
  logic signed [VALUE_BITS-1:0] set_store[MAX_ITEMS];
  int                           set_count = 0;
  logic                         set_overflow = 1'b0;
  int                           items_outstanding = 0;
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  int                           errors = 0;
  int                           elems_accepted = 0;
  int                           sets_sorted = 0;
  int                           overflow_sets = 0;
  int                           results_checked = 0;
  int                           quiet_cycles = 0;
  int                           hold_left = 0;
  logic                         hold_go = 1'b0;
  logic                         hold_used = 1'b0;

  // directed sets: extremes, single element, equal pairs, already sorted,
  // reversed, and the sign boundary where a subtracting compare overflows
  logic [VALUE_BITS-1:0] directed_vals[DIRECTED_LEN] = '{
    32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff, 32'h00000001,
    32'h80000000,
    32'h00000005, 32'h00000005, 32'hfffffffb, 32'hfffffffb,
    32'hfffffffd, 32'hfffffffe, 32'hffffffff, 32'h00000000, 32'h00000007,
    32'h00000004, 32'h00000003, 32'h00000002, 32'h00000001,
    32'h7fffffff, 32'h80000000
  };
  logic directed_last[DIRECTED_LEN] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1
  };

  // mismatch report: one line per failure
  task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                                 input logic [VALUE_BITS-1:0] want);
    errors++;
    $display("MISMATCH t=%0t %s: got %h want %h", $time, what, got, want);
  endtask

  // element store update; a marked last item sorts the set and queues the read-out
  task automatic absorb_element(input logic [VALUE_BITS-1:0] raw, input logic mark_last);
    sorted_item_t                 res;
    logic signed [VALUE_BITS-1:0] tmp;
    int                           n;
    bit                           swapped;
    // element width equals the field width here, so the value is kept as it is
    if (set_count < MAX_ITEMS) begin
      set_store[set_count] = raw;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (mark_last) begin
      n = set_count;
      // bubble sort, strictly greater swaps, stop after a pass with no swap
      for (int p = 0; p + 1 < n; p++) begin
        swapped = 1'b0;
        for (int j = 0; j + 1 < n - p; j++) begin
          if (set_store[j] > set_store[j+1]) begin
            tmp            = set_store[j];
            set_store[j]   = set_store[j+1];
            set_store[j+1] = tmp;
            swapped        = 1'b1;
          end
        end
        if (!swapped) break;
      end
      for (int k = 0; k < n; k++) begin
        res.value   = set_store[k];
        res.is_last = (k == n - 1);
        res.dropped = set_overflow;
        sorted_q.push_back(res);
      end
      sets_sorted++;
      if (set_overflow) overflow_sets++;
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic queue_elem(input logic [VALUE_BITS-1:0] value, input logic mark_last);
    elem_item_t it;
    it.value   = value;
    it.is_last = mark_last;
    pending_q.push_back(it);
    items_outstanding++;
  endtask

  // random element: full range, a narrow band that makes duplicates, or an extreme
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = VALUE_BITS'($signed($urandom_range(0, 8)) - 4);
      end
      1: begin
        v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic queue_random_set(input int n);
    for (int i = 0; i < n; i++) queue_elem(pick_value(), i == n - 1);
  endtask

  task automatic wait_drained();
    while (items_outstanding != 0 || sorted_q.size() != 0) @(posedge clk);
  endtask

  // driver: offer the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        absorb_element(s_axis_tdata, s_axis_tlast);
        elems_accepted++;
        items_outstanding--;
      end
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_q[0].value;
        s_axis_tlast  <= pending_q[0].is_last;
        void'(pending_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (sorted_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          if (m_axis_tdata !== sorted_q[0].value)
            report_mismatch("sorted_value", m_axis_tdata, sorted_q[0].value);
          if (m_axis_tlast !== sorted_q[0].is_last)
            report_mismatch("last_out", 32'(m_axis_tlast), 32'(sorted_q[0].is_last));
          if (m_axis_tuser[0] !== sorted_q[0].dropped)
            report_mismatch("dropped", 32'(m_axis_tuser[0]), 32'(sorted_q[0].dropped));
          void'(sorted_q.pop_front());
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d items and %0d results outstanding",
                 items_outstanding, sorted_q.size());
        $display("bubble_sort_engine verification failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    int phase_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sets with no idling
    for (int i = 0; i < DIRECTED_LEN; i++) queue_elem(directed_vals[i], directed_last[i]);
    wait_drained();

    // random sets through each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_items = 0;
      while (phase_items < 3) begin
        int n;
        n = $urandom_range(1, 8);
        queue_random_set(n);
        phase_items += n;
      end
      wait_drained();
    end

    // receiver holds off while two sets are offered, so the input backs up
    hold_go <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    queue_random_set(5);
    queue_random_set(5);
    wait_drained();

    // one set overrunning the store, its last item among the discarded ones
    queue_random_set(MAX_ITEMS + 3);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d elements in %0d sets (%0d overrunning the store), %0d results checked",
             elems_accepted, sets_sorted, overflow_sets, results_checked);
    $display("idling mixes on both sides plus a %0d-cycle receiver hold-off", HOLD_CYCLES);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("bubble_sort_engine verification clean");
    end else begin
      $display("bubble_sort_engine verification failed");
    end
    $finish;
  end

endmodule
